[design/region_id_slot_allocator_assert.svh]
// ----------------------------------------------------------------------------
// region id slot allocator assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REGION_ID_SLOT_ALLOCATOR_ASSERT_SVH
`define REGION_ID_SLOT_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define RISA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RISA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RISA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RISA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/risa_pkg.sv]
// ----------------------------------------------------------------------------
// risa_pkg
// shared constants and types of the region id slot allocator
// ----------------------------------------------------------------------------
package risa_pkg;

  // slot count, power of two
  localparam int unsigned SLOTS    = 64;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PROBE = 4'b0010,
    ST_RMV   = 4'b0100,
    ST_FULL  = 4'b1000
  } state_t;

endpackage

[design/risa_ram.sv]
// ----------------------------------------------------------------------------
// risa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module risa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/region_id_slot_allocator.sv]
// ----------------------------------------------------------------------------
// region id slot allocator
// Keeps 64 region slots. An add request raises the region count and probes
// linearly from (id_base + count + 1 + probe offset) mod 64, one slot per cycle,
// through a single id adder and the slot used bits; it stores the base
// address in the slot ram and returns the new id. An add to a full table
// returns status full. A remove request frees the slot selected by the low
// id bits and returns the stored address, or status empty. An add presents
// its result once the probe loop has stepped over the occupied slots to a
// free one; a remove presents its result from the registered read of the
// slot ram, and an add refused as full passes through ST_FULL. The next
// request is taken in the cycle after the result register is loaded. A
// result that waits holds the sequencer before it loads the next one. One
// request is in flight at a time; the result register lets the next
// request enter while a result waits.
// ----------------------------------------------------------------------------
`include "region_id_slot_allocator_assert.svh"

module region_id_slot_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [risa_pkg::ID_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [risa_pkg::ADDR_W-1:0]    in_phys_addr,
  input  logic [risa_pkg::ID_W-1:0]      in_remove_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [risa_pkg::STATUS_W-1:0]  out_status,
  output logic [risa_pkg::ID_W-1:0]      out_assigned_id,
  output logic [risa_pkg::ADDR_W-1:0]    out_freed_addr
);

  import risa_pkg::*;

  state_t              state_r, state_nxt;
  logic [ID_W-1:0]     id_base_r, id_base_nxt;
  logic [SLOTS-1:0]    slot_used_r, slot_used_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [OFF_W-1:0]    probe_off_r, probe_off_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [ID_W-1:0]     id_sum_r, id_sum_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [SLOT_W-1:0]   rm_slot_r, rm_slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;

  logic                in_acc;
  logic                out_free;
  logic [ID_W-1:0]     probe_id;
  logic [SLOT_W-1:0]   probe_slot;
  logic                probe_hit;
  logic                add_commit;
  logic                rm_hit;
  logic                rm_done;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_data;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign probe_id   = id_sum_r + ID_W'(off_r);
  assign probe_slot = probe_id[SLOT_W-1:0];
  assign probe_hit  = !slot_used_r[probe_slot];
  assign add_commit = (state_r == ST_PROBE) && probe_hit && out_free;
  assign rm_hit     = slot_used_r[rm_slot_r];
  assign rm_done    = (state_r == ST_RMV) && out_free;
  assign ram_rd_en  = in_acc && (in_mode == MODE_REMOVE);

  risa_ram #(
    .WIDTH(ADDR_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (add_commit),
    .wr_addr (probe_slot),
    .wr_data (addr_r),
    .rd_en   (ram_rd_en),
    .rd_addr (in_remove_id[SLOT_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    id_base_nxt    = cfg_we ? cfg_wdata : id_base_r;
    slot_used_nxt  = slot_used_r;
    count_nxt      = count_r;
    probe_off_nxt  = probe_off_r;
    off_nxt        = off_r;
    id_sum_nxt     = id_sum_r;
    addr_nxt       = addr_r;
    rm_slot_nxt    = rm_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_addr_nxt   = out_addr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_REMOVE) begin
            rm_slot_nxt = in_remove_id[SLOT_W-1:0];
            state_nxt   = ST_RMV;
          end else if (count_r >= CNT_W'(SLOTS)) begin
            state_nxt = ST_FULL;
          end else begin
            off_nxt    = probe_off_r;
            id_sum_nxt = id_base_r + ID_W'(count_r) + ID_W'(1);
            addr_nxt   = in_phys_addr;
            state_nxt  = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (probe_hit) begin
          if (out_free) begin
            slot_used_nxt[probe_slot] = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            probe_off_nxt  = off_r;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_OK;
            out_id_nxt     = probe_id;
            out_addr_nxt   = '0;
            state_nxt      = ST_IDLE;
          end
        end else begin
          off_nxt = off_r + OFF_W'(1);
        end
      end
      ST_RMV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = '0;
          if (rm_hit) begin
            slot_used_nxt[rm_slot_r] = 1'b0;
            if (count_r != '0) begin
              count_nxt = count_r - CNT_W'(1);
            end
            out_status_nxt = STATUS_OK;
            out_addr_nxt   = ram_rd_data;
          end else begin
            out_status_nxt = STATUS_EMPTY;
            out_addr_nxt   = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_FULL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_FULL;
          out_id_nxt     = '0;
          out_addr_nxt   = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      id_base_r   <= '0;
      slot_used_r <= '0;
      count_r     <= '0;
      probe_off_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      id_base_r   <= id_base_nxt;
      slot_used_r <= slot_used_nxt;
      count_r     <= count_nxt;
      probe_off_r <= probe_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r        <= off_nxt;
    id_sum_r     <= id_sum_nxt;
    addr_r       <= addr_nxt;
    rm_slot_r    <= rm_slot_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_addr_r   <= out_addr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_id_r;
  assign out_freed_addr  = out_addr_r;

  `RISA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(SLOTS),
                   "region count above slot count")
  `RISA_ASSERT_NXT(a_add_probes, clk, rst_n,
                   in_acc && (in_mode == MODE_ADD) && (count_r < CNT_W'(SLOTS)),
                   state_r == ST_PROBE, "add with room did not start probing")
  `RISA_ASSERT_IMP(a_result_source, clk, rst_n, $rose(out_valid_r),
                   $past(state_r) != ST_IDLE, "result raised without a request in flight")
  `RISA_ASSERT_NXT(a_remove_count, clk, rst_n, rm_done && rm_hit,
                   count_r == $past(count_r) - CNT_W'(1), "remove of used slot did not lower count")

endmodule
